/* rtl/core/tfn_pkg.sv */
// ----------------------------------------------------------------------------
// tfn_pkg
// Shared types and constants for the triangle face normal unit.
// ----------------------------------------------------------------------------
`default_nettype none

package tfn_pkg;

    localparam int CoordW     = 16;
    localparam int EdgeW      = 17;
    localparam int CrossW     = 35;
    localparam int MagW       = 34;
    localparam int HalfW      = 17;
    localparam int SqW        = 68;
    localparam int SumW       = 70;
    localparam int QuotW      = 29;
    localparam int RootW      = 15;
    localparam int OutW       = 16;
    localparam int QueueDepth = 4;

    typedef struct packed {
        logic signed [CoordW-1:0] ax;
        logic signed [CoordW-1:0] ay;
        logic signed [CoordW-1:0] az;
        logic signed [CoordW-1:0] bx;
        logic signed [CoordW-1:0] by_coord;
        logic signed [CoordW-1:0] bz;
        logic signed [CoordW-1:0] cx;
        logic signed [CoordW-1:0] cy;
        logic signed [CoordW-1:0] cz;
    } tri_item_t;

    typedef struct packed {
        logic signed [OutW-1:0] nx;
        logic signed [OutW-1:0] ny;
        logic signed [OutW-1:0] nz;
        logic                   degenerate;
    } norm_item_t;

    typedef struct packed {
        logic signed [CrossW-1:0] crx;
        logic signed [CrossW-1:0] cry;
        logic signed [CrossW-1:0] crz;
        logic                     degenerate;
    } cross_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

endpackage

`default_nettype wire

/* rtl/core/triangle_face_normal_unit.sv */
// ----------------------------------------------------------------------------
// triangle_face_normal_unit
// Unit face normal of a triangle: cross product of the edges from vertex a to b
// and from a to c, scaled to unit length, Q1.14 components rounded toward zero.
// ----------------------------------------------------------------------------
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-------------------------------------
//  tri      | tri_valid / tri_stall | tri_item  : nine Q7.8 coordinates
//  norm     | norm_valid/norm_stall | norm_item : nx ny nz Q1.14, degenerate
//
//  One item per cycle sustained unless norm_stall or a full queue holds it;
//  path: edge register, queue, three square/sum stages, 29 divide steps,
//  15 root steps, output register.
//  Reset clears valids, queue pointers and the queue count only; no clearing pass.
//  norm_stall with norm_valid high freezes the back pipeline; the queue and the
//  front keep taking items until the queue fills.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_face_normal_unit #(
    parameter int QUEUE_DEPTH = tfn_pkg::QueueDepth
) (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        tri_valid,
    output logic                       tri_stall,
    input  tfn_pkg::tri_item_t         tri_item,
    output logic                       norm_valid,
    input  wire                        norm_stall,
    output tfn_pkg::norm_item_t        norm_item
);
    import tfn_pkg::*;

    // front to queue
    logic        push;
    cross_item_t push_item;
    // queue to back
    logic        pop;
    cross_item_t head_item;
    queue_stat_t qstat;

    // edges and cross product, zero test
    tfn_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .tri_valid (tri_valid),
        .tri_stall (tri_stall),
        .tri_item  (tri_item),
        .qstat     (qstat),
        .push      (push),
        .push_item (push_item)
    );

    // decouples the front from output stalls
    tfn_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .qstat     (qstat)
    );

    // normalisation pipeline
    tfn_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .qstat      (qstat),
        .head_item  (head_item),
        .pop        (pop),
        .norm_valid (norm_valid),
        .norm_stall (norm_stall),
        .norm_item  (norm_item)
    );

`ifndef SYNTHESIS
    // a degenerate item carries a zero vector
    a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        norm_valid && norm_item.degenerate |->
            norm_item.nx == '0 && norm_item.ny == '0 && norm_item.nz == '0)
        else $error("degenerate item with non-zero normal");

    // a proper normal is never the zero vector
    a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        norm_valid && !norm_item.degenerate |->
            norm_item.nx != '0 || norm_item.ny != '0 || norm_item.nz != '0)
        else $error("non-degenerate item with zero normal");

    // queue cannot be both full and empty
    a_queue_sane: assert property (@(posedge clk) disable iff (!rst_n)
        !(qstat.full && qstat.empty))
        else $error("queue full and empty at once");
`endif

endmodule

`default_nettype wire

/* rtl/core/tfn_front.sv */
// ----------------------------------------------------------------------------
// tfn_front
// Takes triangles, registers the edge vectors, forms the cross product and
// flags zero normals before the item goes into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module tfn_front (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        tri_valid,
    output logic                       tri_stall,
    input  tfn_pkg::tri_item_t         tri_item,
    input  tfn_pkg::queue_stat_t       qstat,
    output logic                       push,
    output tfn_pkg::cross_item_t       push_item
);
    import tfn_pkg::*;

    logic                    hold_reg;
    logic signed [EdgeW-1:0] e1x_reg, e1y_reg, e1z_reg;
    logic signed [EdgeW-1:0] e2x_reg, e2y_reg, e2z_reg;
    logic                    load;
    // 17 x 17 partial products, full width
    logic signed [2*EdgeW-1:0] p_yz, p_zy, p_zx, p_xz, p_xy, p_yx;

    assign push      = hold_reg && !qstat.full;
    assign load      = !hold_reg || push;
    assign tri_stall = !load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg <= 1'b0;
        end
        else if (load)
        begin
            hold_reg <= tri_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && tri_valid)
        begin
            e1x_reg <= EdgeW'(tri_item.bx)       - EdgeW'(tri_item.ax);
            e1y_reg <= EdgeW'(tri_item.by_coord) - EdgeW'(tri_item.ay);
            e1z_reg <= EdgeW'(tri_item.bz)       - EdgeW'(tri_item.az);
            e2x_reg <= EdgeW'(tri_item.cx)       - EdgeW'(tri_item.ax);
            e2y_reg <= EdgeW'(tri_item.cy)       - EdgeW'(tri_item.ay);
            e2z_reg <= EdgeW'(tri_item.cz)       - EdgeW'(tri_item.az);
        end
    end

    always_comb
    begin
        p_yz = e1y_reg * e2z_reg;
        p_zy = e1z_reg * e2y_reg;
        p_zx = e1z_reg * e2x_reg;
        p_xz = e1x_reg * e2z_reg;
        p_xy = e1x_reg * e2y_reg;
        p_yx = e1y_reg * e2x_reg;
        push_item.crx = CrossW'(p_yz) - CrossW'(p_zy);
        push_item.cry = CrossW'(p_zx) - CrossW'(p_xz);
        push_item.crz = CrossW'(p_xy) - CrossW'(p_yx);
        push_item.degenerate = (push_item.crx == '0) && (push_item.cry == '0)
                               && (push_item.crz == '0);
    end

endmodule

`default_nettype wire

/* rtl/core/tfn_queue.sv */
// ----------------------------------------------------------------------------
// tfn_queue
// Short queue of cross products between the front and the back pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module tfn_queue #(
    parameter int DEPTH = tfn_pkg::QueueDepth
) (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        push,
    input  tfn_pkg::cross_item_t       push_item,
    input  wire                        pop,
    output tfn_pkg::cross_item_t       head_item,
    output tfn_pkg::queue_stat_t       qstat
);
    import tfn_pkg::*;

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    cross_item_t     mem [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CntW-1:0] count_reg;
    logic            do_pop;

    assign qstat.full  = (count_reg == CntW'(DEPTH));
    assign qstat.empty = (count_reg == '0);
    assign do_pop      = pop && !qstat.empty;
    assign head_item   = mem[rd_ptr_reg];

    function automatic logic [PtrW-1:0] wrap_inc(input logic [PtrW-1:0] p);
        logic [PtrW-1:0] r;
        r = (p == PtrW'(DEPTH - 1)) ? '0 : p + 1'b1;
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wrap_inc(wr_ptr_reg);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= wrap_inc(rd_ptr_reg);
            end
            if (push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/tfn_back.sv */
// ----------------------------------------------------------------------------
// tfn_back
// Squares, length squared, restoring divide of c^2*2^28 by |n|^2, then a
// bit-by-bit integer root; one step per stage, all stages move together.
// ----------------------------------------------------------------------------
`default_nettype none

module tfn_back (
    input  wire                        clk,
    input  wire                        rst_n,
    input  tfn_pkg::queue_stat_t       qstat,
    input  tfn_pkg::cross_item_t       head_item,
    output logic                       pop,
    output logic                       norm_valid,
    input  wire                        norm_stall,
    output tfn_pkg::norm_item_t        norm_item
);
    import tfn_pkg::*;

    // stage map: 0 partial products, 1 squares, 2 sum,
    // 3..3+QuotW-1 divide, then RootW root stages, then output
    localparam int DivFirst  = 3;
    localparam int RootFirst = DivFirst + QuotW;
    localparam int OutStage  = RootFirst + RootW;
    localparam int NumStages = OutStage + 1;

    logic                 adv;
    logic [NumStages-1:0] vld_reg;

    assign adv        = !vld_reg[NumStages-1] || !norm_stall;
    assign pop        = adv;
    assign norm_valid = vld_reg[NumStages-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NumStages-2:0], !qstat.empty};
        end
    end

    // side band carried down to the stage before the output
    logic [2:0] neg_reg [OutStage];
    logic       deg_reg [OutStage];

    // stage 0: magnitudes split in halves, partial products
    logic [2*HalfW-1:0] hh_reg [3];
    logic [2*HalfW-1:0] hl_reg [3];
    logic [2*HalfW-1:0] ll_reg [3];
    logic [SqW-1:0]     sq_reg [3];
    logic [SumW-1:0]    sum_reg;
    logic [SqW-1:0]     sq2_reg [3];

    logic signed [CrossW-1:0] comp [3];
    logic        [MagW-1:0]   mag [3];

    always_comb
    begin
        comp[0] = head_item.crx;
        comp[1] = head_item.cry;
        comp[2] = head_item.crz;
        for (int k = 0; k < 3; k++)
        begin
            mag[k] = comp[k][CrossW-1] ? MagW'(-comp[k]) : MagW'(comp[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                hh_reg[k] <= mag[k][MagW-1:HalfW] * mag[k][MagW-1:HalfW];
                hl_reg[k] <= mag[k][MagW-1:HalfW] * mag[k][HalfW-1:0];
                ll_reg[k] <= mag[k][HalfW-1:0]    * mag[k][HalfW-1:0];
                neg_reg[0][k] <= comp[k][CrossW-1];
            end
            deg_reg[0] <= head_item.degenerate;

            for (int k = 0; k < 3; k++)
            begin
                sq_reg[k] <= (SqW'(hh_reg[k]) << (2*HalfW))
                           + (SqW'(hl_reg[k]) << (HalfW+1))
                           + SqW'(ll_reg[k]);
            end

            sum_reg <= SumW'(sq_reg[0]) + SumW'(sq_reg[1]) + SumW'(sq_reg[2]);
            for (int k = 0; k < 3; k++)
            begin
                sq2_reg[k] <= sq_reg[k];
            end

            for (int s = 1; s < OutStage; s++)
            begin
                neg_reg[s] <= neg_reg[s-1];
                deg_reg[s] <= deg_reg[s-1];
            end
        end
    end

    // divide stages: entry d holds the state after step d
    logic [SumW-1:0]  rem_reg  [QuotW-1][3];
    logic [QuotW-1:0] quo_reg  [QuotW][3];
    logic [SumW-1:0]  dvs_reg  [QuotW-1];

    genvar d, k;
    generate
        for (d = 0; d < QuotW; d++)
        begin : g_div
            logic [SumW-1:0] dvs_in;
            if (d == 0)
            begin : g_head
                assign dvs_in = sum_reg;
            end
            else
            begin : g_body
                assign dvs_in = dvs_reg[d-1];
            end
            if (d < QuotW - 1)
            begin : g_pass
                always_ff @(posedge clk)
                begin
                    if (adv)
                    begin
                        dvs_reg[d] <= dvs_in;
                    end
                end
            end
            for (k = 0; k < 3; k++)
            begin : g_lane
                logic [SumW-1:0]  rem_in;
                logic [QuotW-1:0] quo_in;
                logic [SumW:0]    shifted;
                logic             fits;
                logic             bit_in;
                // only the first step brings in a non-zero numerator bit
                if (d == 0)
                begin : g_head
                    assign rem_in = SumW'(sq2_reg[k] >> 1);
                    assign quo_in = '0;
                    assign bit_in = sq2_reg[k][0];
                end
                else
                begin : g_body
                    assign rem_in = rem_reg[d-1][k];
                    assign quo_in = quo_reg[d-1][k];
                    assign bit_in = 1'b0;
                end
                assign shifted = {rem_in, bit_in};
                assign fits    = (shifted >= {1'b0, dvs_in});
                always_ff @(posedge clk)
                begin
                    if (adv)
                    begin
                        quo_reg[d][k] <= {quo_in[QuotW-2:0], fits};
                    end
                end
                if (d < QuotW - 1)
                begin : g_rem
                    always_ff @(posedge clk)
                    begin
                        if (adv)
                        begin
                            rem_reg[d][k] <= fits ? SumW'(shifted - {1'b0, dvs_in})
                                                  : SumW'(shifted);
                        end
                    end
                end
            end
        end
    endgenerate

    // root stages: entry r holds the state after step r
    logic [QuotW-1:0] rad_reg  [RootW-1][3];
    logic [RootW-1:0] root_reg [RootW][3];

    genvar r;
    generate
        for (r = 0; r < RootW; r++)
        begin : g_root
            for (k = 0; k < 3; k++)
            begin : g_lane
                logic [QuotW-1:0]   rad_in;
                logic [RootW-1:0]   root_in;
                logic [RootW-1:0]   trial;
                logic [2*RootW-1:0] trial_sq;
                if (r == 0)
                begin : g_head
                    assign rad_in  = quo_reg[QuotW-1][k];
                    assign root_in = '0;
                end
                else
                begin : g_body
                    assign rad_in  = rad_reg[r-1][k];
                    assign root_in = root_reg[r-1][k];
                end
                assign trial    = root_in | (RootW'(1) << (RootW - 1 - r));
                assign trial_sq = trial * trial;
                always_ff @(posedge clk)
                begin
                    if (adv)
                    begin
                        root_reg[r][k] <= (trial_sq <= (2*RootW)'(rad_in))
                                          ? trial : root_in;
                    end
                end
                if (r < RootW - 1)
                begin : g_pass
                    always_ff @(posedge clk)
                    begin
                        if (adv)
                        begin
                            rad_reg[r][k] <= rad_in;
                        end
                    end
                end
            end
        end
    endgenerate

    // output register
    logic [OutW-1:0] res [3];

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            res[j] = neg_reg[OutStage-1][j] ? OutW'(-OutW'(root_reg[RootW-1][j]))
                                            : OutW'(root_reg[RootW-1][j]);
            if (deg_reg[OutStage-1])
            begin
                res[j] = '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            norm_item.nx         <= res[0];
            norm_item.ny         <= res[1];
            norm_item.nz         <= res[2];
            norm_item.degenerate <= deg_reg[OutStage-1];
        end
    end

endmodule

`default_nettype wire
